// ===== design/dst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dst_pkg
// Shared types and constants of the deadline slot timer: request kinds,
// error codes, result layout and sequencer states.
// ----------------------------------------------------------------------------
package dst_pkg;

    // table geometry
    localparam int SLOT_COUNT = 4;
    localparam int SLOT_AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SLOT_FW    = 4;
    localparam int TIME_W     = 64;
    localparam int KIND_W     = 2;
    localparam int CODE_W     = 2;

    // request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK    = 2'd0,
        KIND_SET     = 2'd1,
        KIND_CANCEL  = 2'd2,
        KIND_UNKNOWN = 2'd3
    } t_kind;

    // error codes
    typedef enum logic [CODE_W-1:0] {
        ERR_ARMED = 2'd0,
        ERR_RANGE = 2'd1,
        ERR_KIND  = 2'd2
    } t_err;

    // result kinds
    localparam logic RES_TIMEOUT = 1'b0;
    localparam logic RES_ERROR   = 1'b1;

    // one result beat
    typedef struct packed {
        logic              result_kind;
        logic [SLOT_FW-1:0] result_slot;
        logic [CODE_W-1:0] error_code;
        logic [TIME_W-1:0] stamp;
        logic              last;
    } t_res;

    // result handed from the sequencer to the output stage
    typedef struct packed {
        logic valid;
        t_res res;
    } t_push;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_DRAIN = 2'd2,
        S_EMIT  = 2'd3
    } t_state;

endpackage : dst_pkg
`default_nettype wire

// ===== design/dst_chan_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dst_chan_if
// Valid/ready channels of the deadline slot timer: the request channel and
// the result channel.
// ----------------------------------------------------------------------------
interface dst_req_if;
    logic                          valid;
    logic                          ready;
    logic [dst_pkg::KIND_W-1:0]    kind;
    logic [dst_pkg::SLOT_FW-1:0]   slot;
    logic [dst_pkg::TIME_W-1:0]    deadline;
    logic [dst_pkg::TIME_W-1:0]    now;

    modport source (output valid, kind, slot, deadline, now, input ready);
    modport sink   (input valid, kind, slot, deadline, now, output ready);
endinterface : dst_req_if

interface dst_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          result_kind;
    logic [dst_pkg::SLOT_FW-1:0]   result_slot;
    logic [dst_pkg::CODE_W-1:0]    error_code;
    logic [dst_pkg::TIME_W-1:0]    stamp;
    logic                          last;

    modport source (output valid, result_kind, result_slot, error_code, stamp, last,
                    input ready);
    modport sink   (input valid, result_kind, result_slot, error_code, stamp, last,
                    output ready);
endinterface : dst_rsp_if
`default_nettype wire

// ===== design/dst_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dst_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module dst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                            i_wdata,
    input  wire logic                                        i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule : dst_ram
`default_nettype wire

// ===== design/dst_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dst_seq
// Request sequencer: decodes requests, keeps the armed flags, scans the
// deadline RAM one slot a cycle on a tick, and emits expired slots in order.
// ----------------------------------------------------------------------------
module dst_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    dst_req_if.sink                            i_req,
    input  wire logic                          i_out_free,
    output dst_pkg::t_push                     o_push,
    output logic                               o_ram_we,
    output logic [dst_pkg::SLOT_AW-1:0]        o_ram_waddr,
    output logic [dst_pkg::TIME_W-1:0]         o_ram_wdata,
    output logic                               o_ram_re,
    output logic [dst_pkg::SLOT_AW-1:0]        o_ram_raddr,
    input  wire logic [dst_pkg::TIME_W-1:0]    i_ram_rdata
);
    import dst_pkg::*;

    t_state r_state, n_state;
    logic [SLOT_COUNT-1:0] r_armed;
    logic [SLOT_COUNT-1:0] r_mask;
    logic [SLOT_AW-1:0]    r_idx;
    logic                  r_cmp_v;
    logic [SLOT_AW-1:0]    r_cmp_idx;
    logic [TIME_W-1:0]     r_now;

    logic                  req_fire;
    t_kind                 kind;
    logic                  in_range;
    logic [SLOT_AW-1:0]    idx;
    logic                  idx_armed;
    logic                  hit;
    logic [SLOT_AW-1:0]    pick;
    logic [SLOT_COUNT-1:0] pick_bit;
    logic                  pick_last;
    logic                  emit;

    // decode the request beat
    assign req_fire  = i_req.valid && i_req.ready;
    assign kind      = t_kind'(i_req.kind);
    assign in_range  = {1'b0, i_req.slot} < (SLOT_FW + 1)'(SLOT_COUNT);
    assign idx       = i_req.slot[SLOT_AW-1:0];
    assign idx_armed = in_range && r_armed[idx];

    // compare the deadline read last cycle
    assign hit = r_cmp_v && r_armed[r_cmp_idx] && (r_now >= i_ram_rdata);

    // pick the lowest expired slot
    always_comb begin
        pick     = '0;
        pick_bit = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                pick = SLOT_AW'(i);
            end
        end
        pick_bit[pick] = 1'b1;
        pick_last      = (r_mask & ~pick_bit) == '0;
    end

    assign emit = (r_state == S_EMIT) && i_out_free && (r_mask != '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_fire && kind == KIND_TICK) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx == SLOT_AW'(SLOT_COUNT - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (r_mask == '0 || (emit && pick_last)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        i_req.ready  = (r_state == S_IDLE) && i_out_free;
        o_ram_we     = req_fire && kind == KIND_SET && in_range && !idx_armed;
        o_ram_waddr  = idx;
        o_ram_wdata  = i_req.deadline;
        o_ram_re     = (r_state == S_SCAN);
        o_ram_raddr  = r_idx;

        o_push                 = '0;
        o_push.res.result_slot = i_req.slot;
        o_push.res.result_kind = RES_ERROR;
        o_push.res.last        = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    if (kind == KIND_UNKNOWN) begin
                        o_push.valid          = 1'b1;
                        o_push.res.error_code = ERR_KIND;
                    end else if (kind != KIND_TICK && !in_range) begin
                        o_push.valid          = 1'b1;
                        o_push.res.error_code = ERR_RANGE;
                    end else if (kind == KIND_SET && idx_armed) begin
                        o_push.valid          = 1'b1;
                        o_push.res.error_code = ERR_ARMED;
                    end
                end
            end
            S_EMIT: begin
                o_push.valid           = emit;
                o_push.res.result_kind = RES_TIMEOUT;
                o_push.res.result_slot = SLOT_FW'(pick);
                o_push.res.error_code  = '0;
                o_push.res.stamp       = r_now;
                o_push.res.last        = pick_last;
            end
            default: begin
                o_push.valid = 1'b0;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // armed flags: set, cancel and expiry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= '0;
        end else begin
            if (o_ram_we) begin
                r_armed[idx] <= 1'b1;
            end
            if (req_fire && kind == KIND_CANCEL && in_range) begin
                r_armed[idx] <= 1'b0;
            end
            if (hit) begin
                r_armed[r_cmp_idx] <= 1'b0;
            end
        end
    end

    // expired-slot mask: clear on tick, collect on scan, drop on emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (req_fire && kind == KIND_TICK) begin
            r_mask <= '0;
        end else begin
            if (hit) begin
                r_mask[r_cmp_idx] <= 1'b1;
            end
            if (emit) begin
                r_mask <= r_mask & ~pick_bit;
            end
        end
    end

    // scan address and compare stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_cmp_v <= 1'b0;
        end else begin
            r_cmp_v <= (r_state == S_SCAN);
            if (req_fire && kind == KIND_TICK) begin
                r_idx <= '0;
            end else if (r_state == S_SCAN && r_idx != SLOT_AW'(SLOT_COUNT - 1)) begin
                r_idx <= r_idx + SLOT_AW'(1);
            end
        end
    end

    // hold the tick time and the slot in compare
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_idx;
        if (req_fire && kind == KIND_TICK) begin
            r_now <= i_req.now;
        end
    end

endmodule : dst_seq
`default_nettype wire

// ===== design/dst_out_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dst_out_reg
// Output register of the result channel: holds one result beat until the
// receiver takes it, and reports when it can load the next one.
// ----------------------------------------------------------------------------
module dst_out_reg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire dst_pkg::t_push i_push,
    output logic                o_free,
    dst_rsp_if.source           o_rsp
);
    import dst_pkg::*;

    logic r_valid;
    t_res r_res;

    assign o_free = !r_valid || o_rsp.ready;

    // load a new beat or drop the taken one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push.valid) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_res <= i_push.res;
        end
    end

    // drive the channel
    assign o_rsp.valid       = r_valid;
    assign o_rsp.result_kind = r_res.result_kind;
    assign o_rsp.result_slot = r_res.result_slot;
    assign o_rsp.error_code  = r_res.error_code;
    assign o_rsp.stamp       = r_res.stamp;
    assign o_rsp.last        = r_res.last;

endmodule : dst_out_reg
`default_nettype wire

// ===== design/deadline_slot_timer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_slot_timer
// Table of SLOT_COUNT timeout slots, each with an armed flag and a deadline.
//
// i_req carries one request a beat: tick (with now), set (slot, deadline),
// cancel (slot), or an unknown kind. o_rsp carries result beats: timeouts of
// expired slots in ascending slot order, or a single error; last marks the
// final beat that a request causes. Successful set and cancel, and a tick
// with nothing expired, give no beat.
// Set and cancel complete as the request is accepted; an error beat shows in
// the output register the cycle after the request. A tick reads the deadline
// RAM one slot a cycle, then after the scan emits one timeout beat a cycle
// for its expired slots while the output register is free.
// Reset clears the armed flags, the sequencer and the output register; the
// deadlines are not cleared, and no clearing pass runs.
// A stalled receiver holds the output register; requests and timeout beats
// wait until it frees.
// ----------------------------------------------------------------------------
module deadline_slot_timer (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dst_req_if.sink   i_req,
    dst_rsp_if.source o_rsp
);
    import dst_pkg::*;

    t_push              push;
    logic               out_free;
    logic               ram_we;
    logic [SLOT_AW-1:0] ram_waddr;
    logic [TIME_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [SLOT_AW-1:0] ram_raddr;
    logic [TIME_W-1:0]  ram_rdata;

    // request sequencer
    dst_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_out_free  (out_free),
        .o_push      (push),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    // deadline store
    dst_ram #(
        .WIDTH (TIME_W),
        .DEPTH (SLOT_COUNT)
    ) u_deadline_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // result output register
    dst_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_free  (out_free),
        .o_rsp   (o_rsp)
    );

endmodule : deadline_slot_timer
`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the deadline slot timer. Requests go in through
// the request channel. A scoreboard keeps its own copy of the armed flags
// and deadlines and queues the result beats that each accepted request
// should cause. Every beat on the result channel is compared field by field
// with the oldest queued beat. Directed cases come first: field extremes,
// every kind, and every error. Back-pressure, a full drain and random
// traffic follow, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import dst_pkg::*;

    localparam int WATCHDOG_CYCLES = 1000;
    localparam int SETTLE_CYCLES   = 2 * SLOT_COUNT + 6;
    localparam int LONG_HOLD       = 80;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dst_req_if req_ch ();
    dst_rsp_if rsp_ch ();

    deadline_slot_timer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // scoreboard copy of the slot table
    bit                slot_live   [SLOT_COUNT];
    logic [TIME_W-1:0] slot_expiry [SLOT_COUNT];
    t_res              pending_results [$];

    logic [TIME_W-1:0] time_base       = 64'd1000;
    bit                gaps_on         = 1'b1;
    int                rsp_hold_cycles = 0;
    int                mismatch_count  = 0;
    int                quiet_cycles    = 0;

    always #6 i_clk = ~i_clk;

    // queue a single error beat
    function automatic void push_error(input t_err code, input logic [SLOT_FW-1:0] slot);
        t_res beat;
        beat             = '0;
        beat.result_kind = RES_ERROR;
        beat.result_slot = slot;
        beat.error_code  = code;
        beat.last        = 1'b1;
        pending_results.push_back(beat);
    endfunction

    // update the slot table and queue the beats that one request causes
    function automatic void predict_request(input t_kind kind,
                                            input logic [SLOT_FW-1:0] slot,
                                            input logic [TIME_W-1:0] deadline,
                                            input logic [TIME_W-1:0] now);
        t_res               beat;
        int                 final_hit;
        logic [SLOT_AW-1:0] sidx;
        beat      = '0;
        final_hit = -1;
        sidx      = slot[SLOT_AW-1:0];
        case (kind)
            KIND_TICK: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (slot_live[i] && now >= slot_expiry[i]) final_hit = i;
                end
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (slot_live[i] && now >= slot_expiry[i]) begin
                        slot_live[i]     = 1'b0;
                        beat.result_kind = RES_TIMEOUT;
                        beat.result_slot = SLOT_FW'(i);
                        beat.error_code  = '0;
                        beat.stamp       = now;
                        beat.last        = (i == final_hit);
                        pending_results.push_back(beat);
                    end
                end
            end
            KIND_SET, KIND_CANCEL: begin
                if (slot >= SLOT_COUNT) begin
                    push_error(ERR_RANGE, slot);
                end else if (kind == KIND_CANCEL) begin
                    slot_live[sidx] = 1'b0;
                end else if (slot_live[sidx]) begin
                    push_error(ERR_ARMED, slot);
                end else begin
                    slot_expiry[sidx] = deadline;
                    slot_live[sidx]   = 1'b1;
                end
            end
            default: begin
                push_error(ERR_KIND, slot);
            end
        endcase
    endfunction

    // offer one request beat, hold it until accepted, then predict
    task automatic send_request(input t_kind kind, input logic [SLOT_FW-1:0] slot,
                                input logic [TIME_W-1:0] deadline,
                                input logic [TIME_W-1:0] now);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.kind     <= kind;
        req_ch.slot     <= slot;
        req_ch.deadline <= deadline;
        req_ch.now      <= now;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predict_request(kind, slot, deadline, now);
    endtask

    // mostly well-formed traffic around a moving time base, plus noise
    task automatic send_random_request();
        int                 pick;
        t_kind              kind;
        logic [SLOT_FW-1:0] slot;
        logic [TIME_W-1:0]  deadline;
        logic [TIME_W-1:0]  now;
        pick     = $urandom_range(0, 99);
        kind     = t_kind'($urandom_range(0, 3));
        slot     = SLOT_FW'($urandom_range(0, 2**SLOT_FW - 1));
        deadline = {$urandom, $urandom};
        now      = {$urandom, $urandom};
        if (pick < 30) begin
            kind     = KIND_SET;
            slot     = SLOT_FW'($urandom_range(0, SLOT_COUNT - 1));
            deadline = time_base + $urandom_range(0, 60);
        end else if (pick < 55) begin
            time_base = time_base + $urandom_range(0, 25);
            kind      = KIND_TICK;
            now       = time_base;
        end else if (pick < 68) begin
            kind = KIND_CANCEL;
            slot = SLOT_FW'($urandom_range(0, SLOT_COUNT - 1));
        end else if (pick < 78) begin
            kind = $urandom_range(0, 1) ? KIND_SET : KIND_CANCEL;
            if (SLOT_COUNT < 2**SLOT_FW)
                slot = SLOT_FW'($urandom_range(SLOT_COUNT, 2**SLOT_FW - 1));
        end else if (pick < 85) begin
            kind = KIND_UNKNOWN;
        end else if (pick >= 95) begin
            // jump the time base, sometimes right up to the top of the range
            time_base = $urandom_range(0, 1) ? {$urandom, $urandom}
                                             : ~TIME_W'($urandom_range(0, 40));
            kind      = KIND_TICK;
            now       = time_base;
        end
        send_request(kind, slot, deadline, now);
    endtask

    // drop valid and wait until every queued beat has arrived
    task automatic wait_results_drained();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed_cases();
        send_request(KIND_TICK, '0, '1, '0);
        send_request(KIND_SET, '0, '0, '1);
        send_request(KIND_SET, SLOT_FW'(SLOT_COUNT - 1), '1, '0);
        send_request(KIND_SET, '0, 64'd5, '0);
        send_request(KIND_SET, '1, '0, '0);
        send_request(KIND_CANCEL, SLOT_FW'(SLOT_COUNT), '1, '1);
        send_request(KIND_UNKNOWN, '1, '1, '1);
        send_request(KIND_UNKNOWN, '0, '0, '0);
        // deadline equal to now expires
        send_request(KIND_TICK, '0, '1, '0);
        send_request(KIND_CANCEL, '0, '0, '0);
        send_request(KIND_CANCEL, SLOT_FW'(SLOT_COUNT - 1), '0, '0);
        send_request(KIND_TICK, '0, '0, '1);
        for (int i = 0; i < SLOT_COUNT; i++)
            send_request(KIND_SET, SLOT_FW'(i), TIME_W'(100 + 10 * i), '1);
        send_request(KIND_TICK, '1, '0, 64'd110);
        send_request(KIND_TICK, '0, '0, '1);
        send_request(KIND_SET, SLOT_FW'(1 % SLOT_COUNT), '1, '0);
        send_request(KIND_TICK, '0, '0, ~64'd1);
        send_request(KIND_TICK, '0, '0, '1);
    endtask

    // stall the receiver so the block fills up and stops taking requests
    task automatic test_stalled_receiver();
        logic [TIME_W-1:0] base;
        base            = {$urandom, $urandom};
        rsp_hold_cycles = LONG_HOLD;
        repeat (3) begin
            for (int i = 0; i < SLOT_COUNT; i++)
                send_request(KIND_SET, SLOT_FW'(i), base, '0);
            send_request(KIND_TICK, '0, '0, base);
            send_request(KIND_UNKNOWN, SLOT_FW'($urandom_range(0, 15)), '0, '0);
        end
    endtask

    task automatic test_drain_pause();
        repeat (2) begin
            repeat (10) send_random_request();
            wait_results_drained();
        end
    endtask

    task automatic test_random_traffic();
        repeat (200) send_random_request();
    endtask

    // back-to-back on both sides
    task automatic test_quiet_streaming();
        gaps_on = 1'b0;
        repeat (60) send_random_request();
    endtask

    // receiver: random short stalls, one long hold on request
    initial begin : rsp_stall_gen
        int n;
        rsp_ch.ready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rsp_hold_cycles > 0) begin
                n               = rsp_hold_cycles;
                rsp_hold_cycles = 0;
                rsp_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else if (gaps_on && $urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    function automatic void check_field(input string field, input logic [TIME_W-1:0] want_v,
                                        input logic [TIME_W-1:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
            mismatch_count++;
        end
    endfunction

    // compare each accepted result beat with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display({"%0t: unexpected beat, expected none, ",
                          "actual kind %0d slot %0d code %0d stamp %0h last %0d"},
                         $time, rsp_ch.result_kind, rsp_ch.result_slot, rsp_ch.error_code,
                         rsp_ch.stamp, rsp_ch.last);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("result_kind", TIME_W'(want.result_kind), TIME_W'(rsp_ch.result_kind));
                check_field("result_slot", TIME_W'(want.result_slot), TIME_W'(rsp_ch.result_slot));
                check_field("error_code", TIME_W'(want.error_code), TIME_W'(rsp_ch.error_code));
                check_field("stamp", want.stamp, rsp_ch.stamp);
                check_field("last", TIME_W'(want.last), TIME_W'(rsp_ch.last));
            end
        end
    end

    // end the run if nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
            $display("[deadline_slot_timer] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        req_ch.valid    = 1'b0;
        req_ch.kind     = KIND_TICK;
        req_ch.slot     = '0;
        req_ch.deadline = '0;
        req_ch.now      = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_stalled_receiver();
        test_drain_pause();
        test_random_traffic();
        test_quiet_streaming();
        wait_results_drained();

        if (mismatch_count == 0) begin
            $display("[deadline_slot_timer] OK");
        end else begin
            $display("[deadline_slot_timer] ERROR");
        end
        $finish;
    end

endmodule : tb_top
`default_nettype wire

// ===== filelist.f =====
design/dst_pkg.sv
design/dst_chan_if.sv
design/dst_ram.sv
design/dst_seq.sv
design/dst_out_reg.sv
design/deadline_slot_timer.sv
test/tb_top.sv
